// ===== sv/sliding_window_median_macros.svh =====
// assertion macros shared by the sliding window median rtl
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SWM_ASSERT(lbl, clk, rst_n, prop, msg)

`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/swm_pkg.sv =====
// shared types and constants for the sliding window median
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WSIZE_W  = 7;

    localparam logic [WSIZE_W-1:0] RESET_WSIZE = 7'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [WSIZE_W-1:0]         wsize_t;

    // control from the top level to the sorted window
    typedef struct packed {
        logic step;   // one request is processed this cycle
        logic start;  // the request opens a new sequence
        logic clear;  // window size written, empty the window
    } step_req_t;

    typedef struct packed {
        logic    valid;
        sample_t median;
    } result_t;

endpackage

// ===== sv/swm_sorter.sv =====
// sorted window with per-entry age, parallel remove/insert and median select
`include "sliding_window_median_macros.svh"

module swm_sorter
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  step_req_t                        req,
    input  sample_t                          sample,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]  win,
    output result_t                          res
);

    localparam int N  = MAX_WINDOW;
    localparam int AW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);

    sample_t         sorted_reg [N];
    logic [AW-1:0]   age_reg    [N];
    logic [CW-1:0]   fill_reg;

    sample_t         sorted_next [N];
    logic [AW-1:0]   age_next    [N];
    logic [CW-1:0]   fill_next;

    logic [CW-1:0]   count_cur;
    logic            full;
    logic [AW-1:0]   age_top;
    logic [AW-1:0]   mid;

    logic [N-1:0]    valid;
    logic [N-1:0]    rm;
    logic [N-1:0]    le;
    logic [N-1:0]    gone;
    logic [N-1:0]    t_le;
    sample_t         t_val [N];
    logic [AW-1:0]   t_age [N];

    assign count_cur = req.start ? '0 : fill_reg;
    assign full      = (count_cur == win);
    assign age_top   = AW'(win - 1'b1);
    assign mid       = AW'((win - 1'b1) >> 1);
    assign fill_next = full ? count_cur : count_cur + 1'b1;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid[i] = CW'(i) < count_cur;
            // the oldest entry leaves once the window is full
            rm[i]    = full && valid[i] && (age_reg[i] == age_top);
            le[i]    = valid[i] && (sorted_reg[i] <= sample);
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_lane
            // everything at or above the removed slot moves down one place
            assign gone[g] = |rm[g:0];

            if (g < N - 1) begin : g_mid
                assign t_val[g] = gone[g] ? sorted_reg[g+1] : sorted_reg[g];
                assign t_age[g] = gone[g] ? age_reg[g+1]    : age_reg[g];
                assign t_le[g]  = gone[g] ? le[g+1]         : le[g];
            end else begin : g_end
                assign t_val[g] = sorted_reg[g];
                assign t_age[g] = age_reg[g];
                assign t_le[g]  = gone[g] ? 1'b0 : le[g];
            end

            // new sample goes after all entries that are not greater
            if (g == 0) begin : g_first
                always_comb begin
                    if (t_le[g]) begin
                        sorted_next[g] = t_val[g];
                        age_next[g]    = t_age[g] + 1'b1;
                    end else begin
                        sorted_next[g] = sample;
                        age_next[g]    = '0;
                    end
                end
            end else begin : g_rest
                always_comb begin
                    if (t_le[g]) begin
                        sorted_next[g] = t_val[g];
                        age_next[g]    = t_age[g] + 1'b1;
                    end else if (t_le[g-1]) begin
                        sorted_next[g] = sample;
                        age_next[g]    = '0;
                    end else begin
                        sorted_next[g] = t_val[g-1];
                        age_next[g]    = t_age[g-1] + 1'b1;
                    end
                end
            end
        end
    endgenerate

    assign res.valid  = req.step && (fill_next == win);
    assign res.median = sorted_next[mid];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (req.clear) begin
            fill_reg <= '0;
        end else if (req.step) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.step && !req.clear) begin
            for (int i = 0; i < N; i++) begin
                sorted_reg[i] <= sorted_next[i];
                age_reg[i]    <= age_next[i];
            end
        end
    end

    `SWM_ASSERT(fill_in_window, aclk, aresetn, fill_reg <= win, "fill count above window size")
    `SWM_ASSERT(start_refills, aclk, aresetn, (req.step && req.start && !req.clear) |=> (fill_reg == 1'b1), "sequence start did not leave one sample")

    generate
        for (g = 0; g < N - 1; g++) begin : g_chk
            `SWM_ASSERT(order_chk, aclk, aresetn, (CW'(g + 1) < fill_reg) |-> (sorted_reg[g] <= sorted_reg[g+1]), "sorted window out of order")
        end
    endgenerate

endmodule

// ===== sv/sliding_window_median.sv =====
// Running median filter over a sliding window of signed 32-bit samples.
// Input stream s_*: one sample per request in s_tdata, s_tuser set marks the
// start of a new sequence and empties the window before the sample goes in.
// Result stream m_*: the lower median of the window in m_tdata, one result
// per request once the window holds window_size samples; requests made while
// the window fills give no result.
// Config channel cfg_*: writes window_size (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW) and empties the window; write only when idle.
// A taken request waits in the input register, then its result is written to
// the result register; a stall on m_tready can hold it in between.
// Throughput: one request per cycle while m_tready does not stall the result,
// set by the single-pass compare and shift over the sorted window registers,
// which removes the oldest sample and inserts the new one in one step.
// Reset: window empty, window_size 3, no result pending.
// Stall: while m_tready is low a result holds in the output register, one
// more request waits in the input register, and s_tready then drops.
`include "sliding_window_median_macros.svh"

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [31:0] sample
    input  logic                 s_tuser,   // [0] sequence_start

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,   // [31:0] median

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WSIZE_W-1:0]   cfg_data   // window_size
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int RESET_WIN_INT = (MAX_WINDOW < int'(RESET_WSIZE)) ?
                                   MAX_WINDOW : int'(RESET_WSIZE);
    localparam logic [CW-1:0] RESET_WIN = CW'(RESET_WIN_INT);

    logic [CW-1:0] win_reg;
    logic [CW-1:0] win_next;

    logic          in_valid_reg;
    sample_t       in_sample_reg;
    logic          in_start_reg;

    logic          m_valid_reg;
    sample_t       m_data_reg;

    logic          s_accept;
    logic          adv;
    step_req_t     req;
    result_t       res;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data == '0) begin
            win_next = CW'(1);
        end else if (32'(cfg_data) > 32'(MAX_WINDOW)) begin
            win_next = CW'(MAX_WINDOW);
        end else begin
            win_next = CW'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= RESET_WIN;
        end else if (cfg_valid && cfg_ready) begin
            win_reg <= win_next;
        end
    end

    // the held request moves on when the output register is free or drains
    assign adv      = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= sample_t'(s_tdata);
            in_start_reg  <= s_tuser;
        end
    end

    assign req.step  = adv;
    assign req.start = in_start_reg;
    assign req.clear = cfg_valid && cfg_ready;

    swm_sorter #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_sorter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .sample  (in_sample_reg),
        .win     (win_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res.valid) begin
            m_data_reg <= res.median;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SWM_ASSERT(ready_low_only_stalled, aclk, aresetn, !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready), "input blocked without a stalled result")
    `SWM_ASSERT(held_request_kept, aclk, aresetn, (in_valid_reg && !adv) |=> in_valid_reg, "held request dropped before it was processed")
    `SWM_ASSERT(result_from_step, aclk, aresetn, $rose(m_valid_reg) |-> $past(adv), "result appeared without a processed request")
    `SWM_ASSERT_ALWAYS(reset_clears_out, aclk, !aresetn |=> !m_valid_reg, "result valid right after reset")

endmodule

// ===== dv/swm_checker.sv =====
// checker that predicts and compares the lower medians of the sliding window
`timescale 1ns / 1ps

module swm_checker
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,    // [31:0] sample
    input  logic                s_tuser,    // [0] sequence_start

    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [SAMPLE_W-1:0] m_tdata,    // [31:0] median

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [WSIZE_W-1:0]  cfg_data,   // window_size

    output int                  median_errors,
    output int                  medians_pending
);

    wsize_t      window_size_q;
    sample_t     window_ring [MAX_WINDOW];
    sample_t     ordered     [MAX_WINDOW];
    int unsigned held;
    int unsigned oldest;
    sample_t     expected_medians[$];

    initial median_errors = 0;
    initial medians_pending = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: median check: %s", $time, what);
        median_errors++;
    endtask

    // register value 0 acts as 1, values above the store size saturate
    function automatic int unsigned span_of(input wsize_t size);
        if (size == '0)
            return 1;
        if (size > MAX_WINDOW)
            return MAX_WINDOW;
        return size;
    endfunction

    // drop one copy of v from the first count sorted entries
    task automatic drop_from_order(input sample_t v, input int unsigned count);
        int unsigned i;
        i = 0;
        while (i < count && ordered[i] != v)
            i++;
        if (i >= count)
            return;
        for (; i + 1 < count; i++)
            ordered[i] = ordered[i + 1];
    endtask

    task automatic place_in_order(input sample_t v, input int unsigned count);
        int unsigned i;
        i = count;
        while (i > 0 && ordered[i - 1] > v) begin
            ordered[i] = ordered[i - 1];
            i--;
        end
        ordered[i] = v;
    endtask

    task automatic absorb_sample(input sample_t v, input logic start);
        int unsigned w;
        w = span_of(window_size_q);
        if (start || held > w || oldest >= w) begin
            held   = 0;
            oldest = 0;
        end
        if (held < w) begin
            place_in_order(v, held);
            held++;
        end else begin
            drop_from_order(window_ring[oldest], w);
            place_in_order(v, w - 1);
        end
        window_ring[oldest] = v;
        oldest = (oldest + 1 >= w) ? 0 : oldest + 1;
        // even windows take the lower of the two middle values
        if (held == w)
            expected_medians.push_back(ordered[(w - 1) / 2]);
    endtask

    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            window_size_q = RESET_WSIZE;
            held          = 0;
            oldest        = 0;
            expected_medians.delete();
        end else begin
            // a result leaves only after its request has passed the input register, so check first
            if (m_tvalid && m_tready) begin
                if (expected_medians.size() == 0) begin
                    report_mismatch($sformatf("median %0d with none expected",
                                              $signed(m_tdata)));
                end else begin
                    want = expected_medians.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("median %0d, expected %0d",
                                                  $signed(m_tdata), want));
                end
            end
            if (cfg_valid && cfg_ready) begin
                window_size_q = cfg_data;
                held          = 0;
                oldest        = 0;
            end
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata, s_tuser);
        end
        medians_pending <= expected_medians.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// top of the sliding window median testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import swm_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_LIMIT   = 2000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WSIZE_W-1:0]  cfg_data = '0;

    int median_errors;
    int medians_pending;
    bit sender_burst = 1'b0;
    bit receiver_burst = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    sliding_window_median DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    swm_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .median_errors   (median_errors),
        .medians_pending (medians_pending)
    );

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_sample(input sample_t v, input logic start);
        int gap;
        if ($urandom_range(0, 19) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tuser  = start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_window_size(input wsize_t size);
        s_tvalid = 1'b0;
        wait (medians_pending == 0);
        @(negedge aclk);
        // requests that give no median may still be in the pipeline
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = size;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            5, 6, 7: return int'($urandom_range(0, 8)) - 4;
            8: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // result side: random stall before each result
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 19) == 0)
                receiver_burst = !receiver_burst;
            gap = receiver_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // stop the run when nothing moves on any channel for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[sliding_window_median] ERROR");
        $finish;
    end

    initial begin
        wsize_t      sizes [12];
        int unsigned span;
        int unsigned count;

        sizes = '{7'd1, 7'd2, 7'd127, 7'd5, 7'd64, 7'd4, 7'd100, 7'd16, 7'd7, 7'd33,
                  7'd0, 7'd3};
        sizes[10] = wsize_t'($urandom_range(6, 12));

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // window of 3 from reset: extremes, ties, restart inside a window
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);

        // size 0 acts as a window of 1
        write_window_size(7'd0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);

        // even window gives the lower middle value
        write_window_size(7'd2);
        send_sample(32'd10, 1'b0);
        send_sample(32'd20, 1'b0);
        send_sample(32'hFFFF_FFF6, 1'b0);
        send_sample(32'd20, 1'b0);

        for (int p = 0; p < 12; p++) begin
            write_window_size(sizes[p]);
            span  = (sizes[p] == 0) ? 1 : (sizes[p] > 64 ? 64 : sizes[p]);
            count = 50 + span;
            for (int n = 0; n < count; n++) begin
                if (p == 3 && n == count / 2) begin
                    s_tvalid = 1'b0;
                    wait (medians_pending == 0);
                    @(negedge aclk);
                end
                send_sample(random_sample(), $urandom_range(0, 3 * span + 3) == 0);
            end
        end

        s_tvalid = 1'b0;
        wait (medians_pending == 0);
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);
        if (median_errors == 0 && medians_pending == 0)
            $display("[sliding_window_median] OK");
        else
            $display("[sliding_window_median] ERROR");
        $finish;
    end

endmodule
